>>> design/hfx_pkg.sv
// ============================================================================
// hfx_pkg
// Shared constants, types and the control ROM of the header/footer deframer.
// ============================================================================
package hfx_pkg;

    // payload store geometry
    localparam int SLOTS = 20;
    localparam int IDX_W = $clog2(SLOTS);

    // field widths
    localparam int BYTE_W = 8;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 8;
    localparam int LIM_W  = 5;
    localparam int STAT_W = 2;
    localparam int ODATA_W = 24;

    // delimiter bytes
    localparam logic [BYTE_W-1:0] BYTE_FLAG = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_HDR2 = 8'hFE;
    localparam logic [BYTE_W-1:0] BYTE_FTR2 = 8'hFA;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd20;
    localparam logic [LEN_W-1:0] LEN_MAX     = 8'd255;

    // result kinds
    localparam logic [STAT_W-1:0] ST_BYTE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_DROP  = 2'd2;

    // sequencer steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_RECV   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_PUSH2  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_CHECK  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_STATUS = 3'd3;
    localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd4;

    // branch conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_NEVER  = 3'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS = 3'd1;
    localparam logic [COND_W-1:0] COND_FOOTER = 3'd2;
    localparam logic [COND_W-1:0] COND_SPLIT  = 3'd3;
    localparam logic [COND_W-1:0] COND_FITS   = 3'd4;
    localparam logic [COND_W-1:0] COND_DONE   = 3'd5;

    // datapath controls driven by the current step
    typedef struct packed {
        logic in_ready;
        logic push_held;
        logic emit;
        logic is_status;
    } t_ctrl;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic footer;
        logic split;
        logic fits;
        logic done;
    } t_flags;

    // one control word: jump to target on jcond, else step on by acond
    typedef struct packed {
        t_ctrl             ctrl;
        logic [COND_W-1:0] jcond;
        logic [STEP_W-1:0] target;
        logic [COND_W-1:0] acond;
    } t_uword;

    function automatic t_uword rom(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '0;
        case (step)
            STEP_RECV: begin
                w.ctrl.in_ready = 1'b1;
                w.jcond  = COND_FOOTER;
                w.target = STEP_CHECK;
                w.acond  = COND_SPLIT;
            end
            STEP_PUSH2: begin
                w.ctrl.push_held = 1'b1;
                w.jcond  = COND_ALWAYS;
                w.target = STEP_RECV;
                w.acond  = COND_NEVER;
            end
            STEP_CHECK: begin
                w.jcond  = COND_FITS;
                w.target = STEP_EMIT;
                w.acond  = COND_ALWAYS;
            end
            STEP_STATUS: begin
                w.ctrl.emit      = 1'b1;
                w.ctrl.is_status = 1'b1;
                w.jcond  = COND_DONE;
                w.target = STEP_RECV;
                w.acond  = COND_NEVER;
            end
            STEP_EMIT: begin
                w.ctrl.emit = 1'b1;
                w.jcond  = COND_DONE;
                w.target = STEP_RECV;
                w.acond  = COND_NEVER;
            end
            default: begin
                w.jcond  = COND_ALWAYS;
                w.target = STEP_RECV;
                w.acond  = COND_NEVER;
            end
        endcase
        return w;
    endfunction

endpackage

>>> design/hfx_seq.sv
// ============================================================================
// hfx_seq
// Step counter and control ROM: one control word per step, conditional jumps.
// ============================================================================
module hfx_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hfx_pkg::t_flags i_flags,
    output hfx_pkg::t_ctrl  o_ctrl
);

    logic [hfx_pkg::STEP_W-1:0] r_step;
    logic [hfx_pkg::STEP_W-1:0] n_step;
    hfx_pkg::t_uword             w_word;

    function automatic logic test(input logic [hfx_pkg::COND_W-1:0] c,
                                  input hfx_pkg::t_flags f);
        logic res;
        case (c)
            hfx_pkg::COND_NEVER:  res = 1'b0;
            hfx_pkg::COND_ALWAYS: res = 1'b1;
            hfx_pkg::COND_FOOTER: res = f.footer;
            hfx_pkg::COND_SPLIT:  res = f.split;
            hfx_pkg::COND_FITS:   res = f.fits;
            hfx_pkg::COND_DONE:   res = f.done;
            default:              res = 1'b0;
        endcase
        return res;
    endfunction

    // fetch the current control word
    assign w_word = hfx_pkg::rom(r_step);
    assign o_ctrl = w_word.ctrl;

    // jump, advance or hold
    always_comb begin
        if (test(w_word.jcond, i_flags)) begin
            n_step = w_word.target;
        end else if (test(w_word.acond, i_flags)) begin
            n_step = r_step + 1'b1;
        end else begin
            n_step = r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= hfx_pkg::STEP_RECV;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> design/header_footer_frame_extractor_top.sv
// ============================================================================
// header_footer_frame_extractor_top
// Deframes a byte stream delimited by FF FE ... FF FA into payload words.
// ============================================================================
//  channel   | direction | ports                 | content
//  ----------+-----------+-----------------------+-------------------------------
//  rx bytes  | in        | s_axis_*              | tdata[7:0] rx_byte
//  results   | out       | m_axis_*              | tdata byte/position/length,
//            |           |                       | tuser status, tlast last
//  config    | in        | i_cfg_valid/o_cfg_ready| i_cfg_data payload_limit
//
//  A byte is taken in the RECV step; when a held FF and a data byte both go
//  to the store (single write port), the data byte follows in PUSH2. A footer
//  adds a CHECK step, then one word (one store read) per cycle while m_axis_tready is high.
//  Reset (synchronous, active low) returns to hunting with limit 20.
//  A stall on the output holds the sequencer; input is taken only while idle.
// ============================================================================
module header_footer_frame_extractor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // rx_byte[7:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    // payload_byte[7:0], byte_position[12:8], frame_length[20:13], zero [23:21]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [hfx_pkg::ODATA_W-1:0] m_axis_tdata,
    // frame_status[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    hfx_pkg::t_ctrl  w_ctrl;
    hfx_pkg::t_flags w_flags;

    logic [hfx_pkg::LIM_W-1:0]  r_limit;
    logic                       r_mode;
    logic                       n_mode;
    logic                       r_prevff;
    logic                       n_prevff;
    logic [hfx_pkg::BYTE_W-1:0] r_held;
    logic [hfx_pkg::LEN_W-1:0]  r_count;
    logic [hfx_pkg::LEN_W-1:0]  n_count;
    logic [hfx_pkg::POS_W-1:0]  r_pos;
    logic [hfx_pkg::POS_W-1:0]  n_pos;
    logic [hfx_pkg::BYTE_W-1:0] r_store [hfx_pkg::SLOTS];
    logic [hfx_pkg::BYTE_W-1:0] r_rd;

    logic                       r_out_valid;
    logic [hfx_pkg::BYTE_W-1:0] r_out_byte;
    logic [hfx_pkg::POS_W-1:0]  r_out_pos;
    logic [hfx_pkg::LEN_W-1:0]  r_out_len;
    logic [hfx_pkg::STAT_W-1:0] r_out_stat;
    logic                       r_out_last;

    logic                       w_acc;
    logic                       w_hdr;
    logic                       w_push;
    logic [hfx_pkg::BYTE_W-1:0] w_push_data;
    logic [hfx_pkg::LEN_W-1:0]  w_eff_limit;
    logic                       w_out_free;
    logic                       w_fire;
    logic                       w_last;

    hfx_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= hfx_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // decode the incoming byte
    assign s_axis_tready = w_ctrl.in_ready;
    assign w_acc = s_axis_tvalid && w_ctrl.in_ready;
    assign w_hdr = w_acc && !r_mode && r_prevff && (s_axis_tdata == hfx_pkg::BYTE_HDR2);
    assign w_flags.footer = w_acc && r_mode && r_prevff
                            && (s_axis_tdata == hfx_pkg::BYTE_FTR2);
    assign w_flags.split  = w_acc && r_mode && r_prevff
                            && (s_axis_tdata != hfx_pkg::BYTE_FTR2)
                            && (s_axis_tdata != hfx_pkg::BYTE_FLAG);

    // clamp the limit to the store depth and test the length
    assign w_eff_limit = ({3'b000, r_limit} > hfx_pkg::LEN_W'(hfx_pkg::SLOTS))
                         ? hfx_pkg::LEN_W'(hfx_pkg::SLOTS) : {3'b000, r_limit};
    assign w_flags.fits = (r_count != '0) && (r_count < w_eff_limit);

    // result handshake
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_fire     = w_ctrl.emit && w_out_free;
    assign w_last     = w_ctrl.is_status
                        || (({3'b000, r_pos} + 8'd1) == r_count);
    assign w_flags.done = w_fire && w_last;

    // select the byte to store
    always_comb begin
        w_push      = 1'b0;
        w_push_data = s_axis_tdata;
        if (w_ctrl.push_held) begin
            w_push      = 1'b1;
            w_push_data = r_held;
        end else if (w_acc && r_mode && !w_flags.footer) begin
            if (r_prevff) begin
                w_push      = 1'b1;
                w_push_data = hfx_pkg::BYTE_FLAG;
            end else if (s_axis_tdata != hfx_pkg::BYTE_FLAG) begin
                w_push = 1'b1;
            end
        end
    end

    // parser state
    always_comb begin
        n_mode   = r_mode;
        n_prevff = r_prevff;
        if (w_acc) begin
            if (w_hdr) begin
                n_mode   = 1'b1;
                n_prevff = 1'b0;
            end else if (w_flags.footer) begin
                n_mode   = 1'b0;
                n_prevff = 1'b0;
            end else begin
                n_prevff = (s_axis_tdata == hfx_pkg::BYTE_FLAG);
            end
        end
    end

    // length count and read position
    always_comb begin
        n_count = r_count;
        n_pos   = r_pos;
        if (w_flags.done) begin
            n_count = '0;
            n_pos   = '0;
        end else begin
            if (w_hdr) begin
                n_count = '0;
            end else if (w_push && (r_count != hfx_pkg::LEN_MAX)) begin
                n_count = r_count + 1'b1;
            end
            if (w_fire) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_prevff <= 1'b0;
            r_count  <= '0;
            r_pos    <= '0;
        end else begin
            r_mode   <= n_mode;
            r_prevff <= n_prevff;
            r_count  <= n_count;
            r_pos    <= n_pos;
        end
    end

    // hold the byte that may need to be stored in the PUSH2 step
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_held <= s_axis_tdata;
        end
    end

    // payload store: write at the count, read ahead at the next position
    always_ff @(posedge i_clk) begin
        if (w_push && (r_count < hfx_pkg::LEN_W'(hfx_pkg::SLOTS))) begin
            r_store[r_count[hfx_pkg::IDX_W-1:0]] <= w_push_data;
        end
        r_rd <= r_store[hfx_pkg::IDX_W'(n_pos)];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_len  <= r_count;
            r_out_last <= w_last;
            if (w_ctrl.is_status) begin
                r_out_byte <= '0;
                r_out_pos  <= '0;
                r_out_stat <= (r_count == '0) ? hfx_pkg::ST_EMPTY : hfx_pkg::ST_DROP;
            end else begin
                r_out_byte <= r_rd;
                r_out_pos  <= r_pos;
                r_out_stat <= hfx_pkg::ST_BYTE;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_len, r_out_pos, r_out_byte};
    assign m_axis_tuser  = r_out_stat;
    assign m_axis_tlast  = r_out_last;

    // a finished frame leaves an empty count and a rewound position
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_flags.done |=> (r_count == '0) && (r_pos == '0))
        else $error("count or position not cleared after last result");

    // a payload read never runs past the stored length
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.emit && !w_ctrl.is_status) |-> ({3'b000, r_pos} < r_count))
        else $error("read position beyond payload length");

    // status results are always the final word of a frame
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != hfx_pkg::ST_BYTE)) |-> m_axis_tlast)
        else $error("status word without last mark");

    // no byte is taken while results are being produced
    a_no_rx_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.emit |-> !s_axis_tready)
        else $error("input ready during result phase");

endmodule
